// ===== rtl/core/hufd_pkg.sv =====
// hufd_pkg: shared types, constants and helpers of the huffman tree bit decoder
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package hufd_pkg;

  // node table size and derived address width
  localparam int NODE_COUNT = 512;
  localparam int ADDR_W     = $clog2(NODE_COUNT);

  // fixed field widths
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int TRASH_W = 3;
  localparam int CNT_W   = $clog2(BYTE_W + 1);

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;
  localparam logic [CFG_IDX_W-1:0] REG_TRASH_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE  = 1'b1;

  // input item actions
  localparam logic ACT_NODE_WRITE = 1'b0;
  localparam logic ACT_DATA_BYTE  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_DRAIN
  } state_t;

  // sequencer to output stage
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic             flush;
  } emit_cmd_t;

  // output stage to sequencer
  typedef struct packed {
    logic room;
    logic pend_ok;
  } emit_stat_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    idx_ok = (32'(idx) < NODE_COUNT);
  endfunction

endpackage

// ===== rtl/core/hufd_if.sv =====
// hufd_in_if / hufd_out_if: valid-ready channels of the huffman tree bit decoder
// depends on hufd_pkg for field widths
`timescale 1ns / 1ps

interface hufd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [hufd_pkg::IDX_W-1:0]  node_index;
  logic [hufd_pkg::IDX_W-1:0]  left_child;
  logic [hufd_pkg::IDX_W-1:0]  right_child;
  logic                        is_leaf;
  logic [hufd_pkg::SYM_W-1:0]  leaf_symbol;
  logic [hufd_pkg::BYTE_W-1:0] data_byte;
  logic                        final_byte;

  modport source (
    output valid, action, node_index, left_child, right_child, is_leaf,
           leaf_symbol, data_byte, final_byte,
    input  ready
  );
  modport sink (
    input  valid, action, node_index, left_child, right_child, is_leaf,
           leaf_symbol, data_byte, final_byte,
    output ready
  );
endinterface

interface hufd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hufd_pkg::SYM_W-1:0] symbol;
  logic                       last_of_run;

  modport source (output valid, symbol, last_of_run, input ready);
  modport sink   (input valid, symbol, last_of_run, output ready);
endinterface

// ===== rtl/core/hufd_node_mem.sv =====
// hufd_node_mem: node table, one write and one registered read per cycle
// depends on hufd_pkg for node_t and table size
`timescale 1ns / 1ps

module hufd_node_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hufd_pkg::ADDR_W-1:0] waddr,
  input  hufd_pkg::node_t             wdata,
  input  logic                        re,
  input  logic [hufd_pkg::ADDR_W-1:0] raddr,
  output hufd_pkg::node_t             rdata
);

  hufd_pkg::node_t node_mem_r [hufd_pkg::NODE_COUNT];
  hufd_pkg::node_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= node_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hufd_emit.sv =====
// hufd_emit: holds the newest decoded symbol until it is known whether it ends
// the byte, then moves it to the output register; depends on hufd_pkg, hufd_if
`timescale 1ns / 1ps

module hufd_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hufd_pkg::emit_cmd_t  cmd,
  output hufd_pkg::emit_stat_t stat,
  hufd_out_if.source           out_bus
);

  logic                       out_valid_r, out_valid_nxt;
  logic [hufd_pkg::SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       pend_ok_r, pend_ok_nxt;
  logic [hufd_pkg::SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic                       slot_free;
  logic                       room;

  assign slot_free = !out_valid_r || out_bus.ready;
  assign room      = !pend_ok_r || slot_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    pend_ok_nxt   = pend_ok_r;
    pend_sym_nxt  = pend_sym_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.leaf && room) begin
      // a newer leaf means the held symbol is not the last of the byte
      if (pend_ok_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_last_nxt  = 1'b0;
      end
      pend_sym_nxt = cmd.sym;
      pend_ok_nxt  = 1'b1;
    end else if (cmd.flush && pend_ok_r && slot_free) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = pend_sym_r;
      out_last_nxt  = 1'b1;
      pend_ok_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_ok_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_ok_r   <= pend_ok_nxt;
    end
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    pend_sym_r <= pend_sym_nxt;
  end

  assign stat.room    = room;
  assign stat.pend_ok = pend_ok_r;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.symbol      = out_sym_r;
  assign out_bus.last_of_run = out_last_r;

endmodule

// ===== rtl/core/hufd_seq.sv =====
// hufd_seq: sequencer of the tree walk, one child step per cycle through the node table
// read port unless a leaf waits for room in the output stage; depends on hufd_pkg and hufd_if
`timescale 1ns / 1ps

module hufd_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  hufd_in_if.sink                        in_bus,
  input  logic                           cfg_we,
  input  logic [hufd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hufd_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           mem_we,
  output logic [hufd_pkg::ADDR_W-1:0]    mem_waddr,
  output hufd_pkg::node_t                mem_wdata,
  output logic                           mem_re,
  output logic [hufd_pkg::ADDR_W-1:0]    mem_raddr,
  input  hufd_pkg::node_t                mem_rdata,
  output hufd_pkg::emit_cmd_t            cmd,
  input  hufd_pkg::emit_stat_t           stat
);

  hufd_pkg::state_t            state_r, state_nxt;
  logic [hufd_pkg::IDX_W-1:0]   walk_r, walk_nxt;
  logic [hufd_pkg::IDX_W-1:0]   root_r, root_nxt;
  logic [hufd_pkg::TRASH_W-1:0] trash_r, trash_nxt;
  logic                         ent_ok_r, ent_ok_nxt;
  logic                         have_r, have_nxt;
  hufd_pkg::node_t              cur_r, cur_nxt;
  hufd_pkg::node_t              root_ent_r, root_ent_nxt;
  logic [hufd_pkg::IDX_W-1:0]   child_r, child_nxt;
  logic                         child_ok_r, child_ok_nxt;
  logic [hufd_pkg::BYTE_W-1:0]  bits_r, bits_nxt;
  logic [hufd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         final_r, final_nxt;

  hufd_pkg::node_t              rd_ent;
  hufd_pkg::node_t              eff_ent;
  logic [hufd_pkg::IDX_W-1:0]   eff_pos;
  logic [hufd_pkg::IDX_W-1:0]   child;
  logic                         leaf_hit;
  logic                         stall;
  logic                         accept;
  hufd_pkg::node_t              wr_ent;
  logic                         wr_ok;

  // an index past the table reads as an all-zero node
  assign rd_ent   = child_ok_r ? mem_rdata : '0;
  assign leaf_hit = have_r && rd_ent.leaf;
  assign stall    = leaf_hit && !stat.room;
  assign accept   = in_bus.valid && in_bus.ready;

  assign wr_ent.left  = in_bus.left_child;
  assign wr_ent.right = in_bus.right_child;
  assign wr_ent.leaf  = in_bus.is_leaf;
  assign wr_ent.sym   = in_bus.leaf_symbol;
  assign wr_ok        = hufd_pkg::idx_ok(in_bus.node_index);

  // node the walk stands on this cycle
  always_comb begin
    if (leaf_hit) begin
      eff_ent = root_ent_r;
      eff_pos = root_r;
    end else if (have_r) begin
      eff_ent = rd_ent;
      eff_pos = child_r;
    end else begin
      eff_ent = cur_r;
      eff_pos = walk_r;
    end
  end

  assign child = bits_r[hufd_pkg::BYTE_W-1] ? eff_ent.right : eff_ent.left;

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    root_nxt     = root_r;
    trash_nxt    = trash_r;
    ent_ok_nxt   = ent_ok_r;
    have_nxt     = have_r;
    cur_nxt      = cur_r;
    root_ent_nxt = root_ent_r;
    child_nxt    = child_r;
    child_ok_nxt = child_ok_r;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    final_nxt    = final_r;
    mem_we       = 1'b0;
    mem_waddr    = hufd_pkg::ADDR_W'(in_bus.node_index);
    mem_wdata    = wr_ent;
    mem_re       = 1'b0;
    mem_raddr    = hufd_pkg::ADDR_W'(root_r);
    cmd.leaf     = 1'b0;
    cmd.sym      = rd_ent.sym;
    cmd.flush    = 1'b0;
    in_bus.ready = 1'b0;

    case (state_r)
      hufd_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (accept) begin
          if (in_bus.action == hufd_pkg::ACT_NODE_WRITE) begin
            mem_we = wr_ok;
            // keep the cached root and current nodes coherent with the table
            if (wr_ok && in_bus.node_index == root_r) begin
              root_ent_nxt = wr_ent;
            end
            if (wr_ok && in_bus.node_index == walk_r) begin
              cur_nxt = wr_ent;
            end
          end else begin
            bits_nxt  = in_bus.data_byte;
            final_nxt = in_bus.final_byte;
            cnt_nxt   = hufd_pkg::CNT_W'(hufd_pkg::BYTE_W)
                      - (in_bus.final_byte ? hufd_pkg::CNT_W'(trash_r) : '0);
            have_nxt  = 1'b0;
            if (ent_ok_r) begin
              state_nxt = hufd_pkg::ST_STEP;
            end else begin
              mem_re       = 1'b1;
              mem_raddr    = hufd_pkg::ADDR_W'(root_r);
              child_ok_nxt = hufd_pkg::idx_ok(root_r);
              state_nxt    = hufd_pkg::ST_LOAD;
            end
          end
        end
      end

      hufd_pkg::ST_LOAD: begin
        // after reset or a root change the walk stands on the root
        root_ent_nxt = rd_ent;
        cur_nxt      = rd_ent;
        ent_ok_nxt   = 1'b1;
        state_nxt    = hufd_pkg::ST_STEP;
      end

      hufd_pkg::ST_STEP: begin
        cmd.leaf = leaf_hit;
        if (!stall) begin
          if (cnt_r != '0) begin
            mem_re       = 1'b1;
            mem_raddr    = hufd_pkg::ADDR_W'(child);
            child_nxt    = child;
            child_ok_nxt = hufd_pkg::idx_ok(child);
            bits_nxt     = bits_r << 1;
            cnt_nxt      = cnt_r - hufd_pkg::CNT_W'(1);
            have_nxt     = 1'b1;
          end else begin
            walk_nxt  = final_r ? root_r : eff_pos;
            cur_nxt   = final_r ? root_ent_r : eff_ent;
            have_nxt  = 1'b0;
            state_nxt = hufd_pkg::ST_DRAIN;
          end
        end
      end

      hufd_pkg::ST_DRAIN: begin
        cmd.flush = 1'b1;
        if (stat.room) begin
          state_nxt = hufd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hufd_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        hufd_pkg::REG_TRASH_BITS: begin
          trash_nxt = cfg_wdata[hufd_pkg::TRASH_W-1:0];
        end
        hufd_pkg::REG_ROOT_NODE: begin
          root_nxt   = cfg_wdata[hufd_pkg::IDX_W-1:0];
          walk_nxt   = cfg_wdata[hufd_pkg::IDX_W-1:0];
          ent_ok_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hufd_pkg::ST_IDLE;
      walk_r   <= '0;
      root_r   <= '0;
      trash_r  <= '0;
      ent_ok_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      walk_r   <= walk_nxt;
      root_r   <= root_nxt;
      trash_r  <= trash_nxt;
      ent_ok_r <= ent_ok_nxt;
      have_r   <= have_nxt;
    end
    cur_r      <= cur_nxt;
    root_ent_r <= root_ent_nxt;
    child_r    <= child_nxt;
    child_ok_r <= child_ok_nxt;
    bits_r     <= bits_nxt;
    cnt_r      <= cnt_nxt;
    final_r    <= final_nxt;
  end

endmodule

// ===== rtl/core/huffman_tree_bit_decoder.sv =====
// huffman_tree_bit_decoder: a node write is taken in the idle state. a data byte goes from
// idle through load (only after reset or a root_node write), then step with one node table
// read per bit used (8, or 8 - trash_bits on a final byte), then drain back to idle.
// symbols leave through an output register, the last of a byte when its walk ends.
// synchronous active-low reset clears control state; the node table is not cleared.
// depends on hufd_pkg, hufd_if, hufd_node_mem, hufd_seq, hufd_emit
`timescale 1ns / 1ps

module huffman_tree_bit_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  hufd_in_if.sink                        in_bus,
  hufd_out_if.source                     out_bus,
  input  logic                           cfg_we,
  input  logic [hufd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hufd_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                        mem_we;
  logic [hufd_pkg::ADDR_W-1:0] mem_waddr;
  hufd_pkg::node_t             mem_wdata;
  logic                        mem_re;
  logic [hufd_pkg::ADDR_W-1:0] mem_raddr;
  hufd_pkg::node_t             mem_rdata;
  hufd_pkg::emit_cmd_t         cmd;
  hufd_pkg::emit_stat_t        stat;

  hufd_node_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hufd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  hufd_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .out_bus (out_bus)
  );

`ifndef NO_ASSERTIONS
  // no symbol may be left behind when a new beat can be taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !stat.pend_ok)
    else $error("pending symbol while input ready");

  // a data byte keeps the block busy for at least the next cycle
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.action == hufd_pkg::ACT_DATA_BYTE)
    |=> !in_bus.ready)
    else $error("input ready right after a data byte");

  // a node write finishes in its own cycle
  a_node_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.action == hufd_pkg::ACT_NODE_WRITE)
    |=> in_bus.ready)
    else $error("node write did not complete in one cycle");

  // table writes only happen on accepted node writes
  a_write_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_bus.valid && in_bus.ready
                && in_bus.action == hufd_pkg::ACT_NODE_WRITE))
    else $error("node table write without a node write beat");
`endif

endmodule
